// ===== rtl/sedt_pkg.sv =====
package sedt_pkg;

  localparam int MaxLineLen = 512;
  localparam int MaxLines   = 512;

  localparam int PosW     = $clog2(MaxLineLen);
  localparam int LineW    = $clog2(MaxLines);
  localparam int LenW     = $clog2(MaxLineLen + 1);
  localparam int CntW     = $clog2(MaxLines + 1);
  localparam int BpAddrW  = LineW + PosW;
  localparam int CumW     = 17;
  localparam int EnergyW  = 8;
  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 2;

  localparam logic [CumW-1:0] CumMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth    = 2'd0,
    RegImageHeight   = 2'd1,
    RegSeamDirection = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ReqPixel = 1'b0,
    ReqTrace = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    BpLeft  = 2'd0,
    BpMid   = 2'd1,
    BpRight = 2'd2
  } bp_e;

  typedef struct packed {
    logic               req_type;
    logic [EnergyW-1:0] energy;
  } in_item_t;

  typedef struct packed {
    logic [CumW-1:0] cum_energy;
    logic [PosW-1:0] seam_index;
    logic            seam_last;
    logic            status;
  } out_item_t;

  typedef struct packed {
    logic load_pix;
    logic load_trc;
    logic commit_pix;
    logic commit_trc;
    logic commit_err;
  } sedt_cmd_t;

  typedef struct packed {
    logic frame_done;
  } sedt_stat_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [CfgDataW-1:0] v);
    if (v == '0) begin
      return LenW'(1);
    end else if (int'(v) > MaxLineLen) begin
      return LenW'(MaxLineLen);
    end
    return LenW'(v);
  endfunction

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CfgDataW-1:0] v);
    if (v == '0) begin
      return CntW'(1);
    end else if (int'(v) > MaxLines) begin
      return CntW'(MaxLines);
    end
    return CntW'(v);
  endfunction

endpackage

// ===== rtl/sedt_ctrl.sv =====
module sedt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sedt_pkg::sedt_stat_t stat_i,
  output sedt_pkg::sedt_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StPixel,
    StTrace
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;
  logic   commit;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  // output register is free when empty or being drained this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_pix   = accept && (in_req_type_i == sedt_pkg::ReqPixel);
    cmd_o.load_trc   = accept && (in_req_type_i == sedt_pkg::ReqTrace);
    cmd_o.commit_pix = (state_q == StPixel) && out_free;
    cmd_o.commit_trc = (state_q == StTrace) && out_free && stat_i.frame_done;
    cmd_o.commit_err = (state_q == StTrace) && out_free && !stat_i.frame_done;
  end

  assign commit = cmd_o.commit_pix || cmd_o.commit_trc || cmd_o.commit_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= (in_req_type_i == sedt_pkg::ReqTrace) ? StTrace : StPixel;
          end
        end
        StPixel, StTrace: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle && !out_free) |=> (state_q == $past(state_q)))
    else $error("work state left while output register was full");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle))
    else $error("accepted word did not start processing");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");

endmodule

// ===== rtl/sedt_dpath.sv =====
module sedt_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sedt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sedt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic [sedt_pkg::EnergyW-1:0]     energy_i,
  input  sedt_pkg::sedt_cmd_t              cmd_i,
  output sedt_pkg::sedt_stat_t             stat_o,
  output sedt_pkg::out_item_t              out_data_o
);

  // configuration
  logic [sedt_pkg::CfgDataW-1:0] cfg_width_q;
  logic [sedt_pkg::CfgDataW-1:0] cfg_height_q;
  logic                          cfg_dir_q;
  logic                          cfg_restart;

  // frame state
  logic [sedt_pkg::PosW-1:0]  pos_q;
  logic [sedt_pkg::LineW-1:0] line_q;
  logic [sedt_pkg::CumW-1:0]  held_left_q;
  logic [sedt_pkg::CumW-1:0]  min_q;
  logic [sedt_pkg::PosW-1:0]  min_pos_q;
  logic [sedt_pkg::PosW-1:0]  trace_pos_q;
  logic [sedt_pkg::LineW-1:0] trace_line_q;
  logic                       frame_done_q;

  // operand and read registers
  logic [sedt_pkg::EnergyW-1:0] energy_q;
  logic [sedt_pkg::CumW-1:0]    mid_q;
  logic [sedt_pkg::CumW-1:0]    right_q;
  sedt_pkg::bp_e                bp_rd_q;
  sedt_pkg::out_item_t          out_q;

  // line buffer and back-pointer store
  logic [sedt_pkg::CumW-1:0] prev_mem [sedt_pkg::MaxLineLen];
  logic [1:0]                bp_mem   [sedt_pkg::MaxLines * sedt_pkg::MaxLineLen];

  logic [sedt_pkg::LenW-1:0]  line_len;
  logic [sedt_pkg::CntW-1:0]  line_cnt;
  logic [sedt_pkg::LineW-1:0] cnt_m1;
  logic [sedt_pkg::LenW-1:0]  pos_inc;
  logic                       line_end;
  logic                       last_line;
  logic                       frame_end;
  logic [sedt_pkg::CumW-1:0]  left_v;
  logic [sedt_pkg::CumW-1:0]  right_v;
  logic [sedt_pkg::CumW-1:0]  min_v;
  sedt_pkg::bp_e              bp_sel;
  logic [sedt_pkg::CumW:0]    sum;
  logic [sedt_pkg::CumW-1:0]  cum;
  sedt_pkg::bp_e              bp_wr;
  logic                       min_take;
  logic [sedt_pkg::PosW-1:0]  min_pos_new;
  logic                       trace_last;
  logic [sedt_pkg::PosW-1:0]  trace_np;
  logic [sedt_pkg::BpAddrW-1:0] bp_wr_addr;
  logic [sedt_pkg::BpAddrW-1:0] bp_rd_addr;

  assign cfg_restart = cfg_we_i && (cfg_idx_i inside {sedt_pkg::RegImageWidth,
                                                      sedt_pkg::RegImageHeight,
                                                      sedt_pkg::RegSeamDirection});

  assign line_len  = sedt_pkg::clamp_len(cfg_dir_q ? cfg_height_q : cfg_width_q);
  assign line_cnt  = sedt_pkg::clamp_cnt(cfg_dir_q ? cfg_width_q : cfg_height_q);
  assign cnt_m1    = sedt_pkg::LineW'(line_cnt - sedt_pkg::CntW'(1));
  assign pos_inc   = sedt_pkg::LenW'(pos_q) + sedt_pkg::LenW'(1);
  assign line_end  = (pos_inc >= line_len);
  assign last_line = (line_q == cnt_m1);
  assign frame_end = line_end && last_line;

  // three-way minimum over the previous line, leftmost wins ties
  always_comb begin
    left_v  = (pos_q == '0) ? mid_q : held_left_q;
    right_v = (pos_inc < line_len) ? right_q : mid_q;
    min_v   = left_v;
    bp_sel  = sedt_pkg::BpLeft;
    if (mid_q < min_v) begin
      min_v  = mid_q;
      bp_sel = sedt_pkg::BpMid;
    end
    if (right_v < min_v) begin
      min_v  = right_v;
      bp_sel = sedt_pkg::BpRight;
    end
  end

  assign sum = {1'b0, min_v} + (sedt_pkg::CumW + 1)'(energy_q);

  always_comb begin
    if (line_q == '0) begin
      cum   = sedt_pkg::CumW'(energy_q);
      bp_wr = sedt_pkg::BpMid;
    end else begin
      cum   = sum[sedt_pkg::CumW] ? sedt_pkg::CumMax : sum[sedt_pkg::CumW-1:0];
      bp_wr = bp_sel;
    end
  end

  assign min_take    = last_line && ((pos_q == '0) || (cum < min_q));
  assign min_pos_new = min_take ? pos_q : min_pos_q;

  // seam step from the stored back-pointer, clamped at the line ends
  assign trace_last = (trace_line_q == '0);
  always_comb begin
    case (bp_rd_q)
      sedt_pkg::BpLeft:
        trace_np = (trace_pos_q == '0) ? trace_pos_q : trace_pos_q - 1'b1;
      sedt_pkg::BpRight:
        trace_np = ((sedt_pkg::LenW'(trace_pos_q) + sedt_pkg::LenW'(1)) < line_len) ?
                   trace_pos_q + 1'b1 : trace_pos_q;
      default:
        trace_np = trace_pos_q;
    endcase
  end

  assign bp_wr_addr = {line_q, pos_q};
  assign bp_rd_addr = {trace_line_q, trace_pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= sedt_pkg::CfgDataW'(sedt_pkg::MaxLineLen);
      cfg_height_q <= sedt_pkg::CfgDataW'(sedt_pkg::MaxLines);
      cfg_dir_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (sedt_pkg::cfg_reg_e'(cfg_idx_i))
        sedt_pkg::RegImageWidth:    cfg_width_q  <= cfg_wdata_i;
        sedt_pkg::RegImageHeight:   cfg_height_q <= cfg_wdata_i;
        sedt_pkg::RegSeamDirection: cfg_dir_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      line_q       <= '0;
      held_left_q  <= '0;
      min_q        <= sedt_pkg::CumMax;
      min_pos_q    <= '0;
      trace_pos_q  <= '0;
      trace_line_q <= '0;
      frame_done_q <= 1'b0;
    end else if (cfg_restart) begin
      pos_q        <= '0;
      line_q       <= '0;
      held_left_q  <= '0;
      trace_pos_q  <= '0;
      trace_line_q <= '0;
      frame_done_q <= 1'b0;
    end else if (cmd_i.commit_pix) begin
      held_left_q <= mid_q;
      if (min_take) begin
        min_q     <= cum;
        min_pos_q <= pos_q;
      end
      if (line_end) begin
        pos_q  <= '0;
        line_q <= frame_end ? '0 : line_q + 1'b1;
      end else begin
        pos_q <= pos_inc[sedt_pkg::PosW-1:0];
      end
      // a pixel after a finished frame opens the next one
      frame_done_q <= frame_end;
      if (frame_end) begin
        trace_pos_q  <= min_pos_new;
        trace_line_q <= cnt_m1;
      end
    end else if (cmd_i.commit_trc) begin
      if (trace_last) begin
        trace_pos_q  <= min_pos_q;
        trace_line_q <= cnt_m1;
      end else begin
        trace_pos_q  <= trace_np;
        trace_line_q <= trace_line_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      energy_q <= energy_i;
      mid_q    <= prev_mem[pos_q];
      right_q  <= prev_mem[pos_inc[sedt_pkg::PosW-1:0]];
    end
    if (cmd_i.commit_pix) begin
      prev_mem[pos_q] <= cum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_trc) begin
      bp_rd_q <= sedt_pkg::bp_e'(bp_mem[bp_rd_addr]);
    end
    if (cmd_i.commit_pix) begin
      bp_mem[bp_wr_addr] <= bp_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_pix) begin
      out_q.cum_energy <= cum;
      out_q.seam_index <= '0;
      out_q.seam_last  <= 1'b0;
      out_q.status     <= 1'b0;
    end else if (cmd_i.commit_trc) begin
      out_q.cum_energy <= '0;
      out_q.seam_index <= trace_pos_q;
      out_q.seam_last  <= trace_last;
      out_q.status     <= 1'b0;
    end else if (cmd_i.commit_err) begin
      out_q.cum_energy <= '0;
      out_q.seam_index <= '0;
      out_q.seam_last  <= 1'b0;
      out_q.status     <= 1'b1;
    end
  end

  assign out_data_o        = out_q;
  assign stat_o.frame_done = frame_done_q;

  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sedt_pkg::LenW'(pos_q) < line_len)
    else $error("line position beyond line length");

  a_line_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sedt_pkg::CntW'(line_q) < line_cnt)
    else $error("line number beyond line count");

  a_done_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done_q |-> (pos_q == '0 && line_q == '0))
    else $error("frame marked done away from frame start");

endmodule

// ===== rtl/seam_energy_dp_and_trace_core.sv =====
// a word is accepted only in the idle state, and the next one only after its result is
//   committed to the output register; operands come from a registered read of the
//   line buffer (pixels) or of the back-pointer store (traces)
// a full output register stalls the block until the result is taken
// reset: frame counters and seam state cleared, sizes 512 x 512, vertical seam;
//   line buffer and back-pointer store are not cleared, no clearing pass
module seam_energy_dp_and_trace_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sedt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sedt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sedt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sedt_pkg::out_item_t           out_data_o
);

  sedt_pkg::sedt_cmd_t  cmd;
  sedt_pkg::sedt_stat_t stat;

  sedt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sedt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .energy_i    (in_data_i.energy),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int          ClkHalf     = 4;
  localparam int          ResetCycles = 7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int          DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomWords = 1720;
  localparam int unsigned IdlePct     = 11;
  localparam int unsigned MaxTraces   = 40;
  localparam int unsigned ShownErrors = 20;

  class seam_dp_scoreboard;
    logic [sedt_pkg::CfgDataW-1:0] width_q;
    logic [sedt_pkg::CfgDataW-1:0] height_q;
    logic                          dir_q;
    logic [sedt_pkg::CumW-1:0]     line_buf [sedt_pkg::MaxLineLen];
    sedt_pkg::bp_e                 bp_store [sedt_pkg::MaxLines*sedt_pkg::MaxLineLen];
    logic [sedt_pkg::CumW-1:0]     left_cum;
    logic [sedt_pkg::CumW-1:0]     min_cum;
    int unsigned                   min_pos, pos, line_no, trc_pos, trc_line;
    bit                            frame_done;
    sedt_pkg::out_item_t           pending_results [$];
    int unsigned                   errors, checked, seams_read, early_traces;

    function new();
      width_q  = 10'd512;
      height_q = 10'd512;
      dir_q    = 1'b0;
      min_cum  = sedt_pkg::CumMax;
      min_pos  = 0;
      restart();
    endfunction

    function void restart();
      pos        = 0;
      line_no    = 0;
      frame_done = 0;
      trc_pos    = 0;
      trc_line   = 0;
      left_cum   = '0;
    endfunction

    function int unsigned clip_size(logic [sedt_pkg::CfgDataW-1:0] v, int unsigned bound);
      if (v == '0) return 1;
      return (v > bound) ? bound : int'(v);
    endfunction

    function int unsigned line_length();
      return clip_size(dir_q ? height_q : width_q, sedt_pkg::MaxLineLen);
    endfunction

    function int unsigned line_total();
      return clip_size(dir_q ? width_q : height_q, sedt_pkg::MaxLines);
    endfunction

    function void write_reg(sedt_pkg::cfg_reg_e idx, logic [sedt_pkg::CfgDataW-1:0] v);
      case (idx)
        sedt_pkg::RegImageWidth:    width_q = v;
        sedt_pkg::RegImageHeight:   height_q = v;
        sedt_pkg::RegSeamDirection: dir_q = v[0];
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void predict_cum_energy(logic [sedt_pkg::EnergyW-1:0] e);
      int unsigned               len, cnt, p, ln;
      logic [sedt_pkg::CumW-1:0] lft, mid, rgt, best, cum;
      logic [sedt_pkg::CumW:0]   sum;
      sedt_pkg::bp_e             pick;
      sedt_pkg::out_item_t       r;
      len = line_length();
      cnt = line_total();
      if (frame_done) restart();
      p  = (pos >= len) ? len - 1 : pos;
      ln = (line_no >= cnt) ? cnt - 1 : line_no;
      if (ln == 0) begin
        cum  = sedt_pkg::CumW'(e);
        pick = sedt_pkg::BpMid;
      end else begin
        lft  = (p == 0) ? line_buf[0] : left_cum;
        mid  = line_buf[p];
        rgt  = (p + 1 < len) ? line_buf[p+1] : mid;
        best = lft;
        pick = sedt_pkg::BpLeft;
        if (mid < best) begin
          best = mid;
          pick = sedt_pkg::BpMid;
        end
        if (rgt < best) begin
          best = rgt;
          pick = sedt_pkg::BpRight;
        end
        sum = {1'b0, best} + (sedt_pkg::CumW + 1)'(e);
        cum = (sum > sedt_pkg::CumMax) ? sedt_pkg::CumMax : sum[sedt_pkg::CumW-1:0];
      end
      // keep the old value at p, it is the left neighbor of the next pixel
      left_cum    = line_buf[p];
      line_buf[p] = cum;
      bp_store[ln*sedt_pkg::MaxLineLen + p] = pick;
      if (ln == cnt - 1 && (p == 0 || cum < min_cum)) begin
        min_cum = cum;
        min_pos = p;
      end
      p++;
      if (p >= len) begin
        p = 0;
        ln++;
        if (ln >= cnt) begin
          ln         = 0;
          frame_done = 1;
          trc_pos    = min_pos;
          trc_line   = cnt - 1;
        end
      end
      pos     = p;
      line_no = ln;
      r = '0;
      r.cum_energy = cum;
      pending_results.push_back(r);
    endfunction

    function void predict_seam_step();
      int unsigned         len, cnt;
      sedt_pkg::out_item_t r;
      len = line_length();
      cnt = line_total();
      r = '0;
      if (!frame_done) begin
        r.status = 1'b1;
        early_traces++;
      end else begin
        if (trc_line >= cnt) trc_line = cnt - 1;
        if (trc_pos >= len) trc_pos = len - 1;
        r.seam_index = sedt_pkg::PosW'(trc_pos);
        r.seam_last  = (trc_line == 0);
        seams_read++;
        if (trc_line == 0) begin
          // rewind so the same seam can be read again
          trc_pos  = min_pos;
          trc_line = cnt - 1;
        end else begin
          case (bp_store[trc_line*sedt_pkg::MaxLineLen + trc_pos])
            sedt_pkg::BpLeft:  if (trc_pos > 0) trc_pos--;
            sedt_pkg::BpRight: if (trc_pos + 1 < len) trc_pos++;
            default: ;
          endcase
          trc_line--;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void note_word(sedt_pkg::in_item_t w);
      if (w.req_type == sedt_pkg::ReqTrace) predict_seam_step();
      else predict_cum_energy(w.energy);
    endfunction

    function void flag(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= ShownErrors)
        $error("%s expected %0d actual %0d", field, exp_v, act_v);
    endfunction

    function void check_result(sedt_pkg::out_item_t got);
      sedt_pkg::out_item_t want;
      checked++;
      if (pending_results.size() == 0) begin
        flag("unexpected word, cum_energy", 0, got.cum_energy);
        return;
      end
      want = pending_results.pop_front();
      if (got.cum_energy !== want.cum_energy)
        flag("cum_energy", want.cum_energy, got.cum_energy);
      if (got.seam_index !== want.seam_index)
        flag("seam_index", want.seam_index, got.seam_index);
      if (got.seam_last !== want.seam_last)
        flag("seam_last", want.seam_last, got.seam_last);
      if (got.status !== want.status)
        flag("status", want.status, got.status);
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [sedt_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [sedt_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  sedt_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  sedt_pkg::out_item_t           out_data_o;

  seam_dp_scoreboard sb = new();

  bit          steady    = 1'b0;
  bit          hold_sink = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_in  = 0;
  int unsigned settings  = 0;

  seam_energy_dp_and_trace_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // sink side: random stalls, one long hold-off, no stalls while steady
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (sink_hold != 0) begin
      sink_hold   <= sink_hold - 1;
      out_ready_i <= 1'b0;
    end else if (hold_sink && !hold_done) begin
      sink_hold   <= HoldCycles;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_word(input sedt_pkg::in_item_t w);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    words_in++;
  endtask

  task automatic send_pixel(input logic [sedt_pkg::EnergyW-1:0] e);
    sedt_pkg::in_item_t w;
    w.req_type = sedt_pkg::ReqPixel;
    w.energy   = e;
    send_word(w);
  endtask

  task automatic send_trace();
    sedt_pkg::in_item_t w;
    w.req_type = sedt_pkg::ReqTrace;
    w.energy   = sedt_pkg::EnergyW'($urandom_range(255));
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [sedt_pkg::CfgDataW-1:0] w,
                           input logic [sedt_pkg::CfgDataW-1:0] h,
                           input logic d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sedt_pkg::RegImageWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    sb.write_reg(sedt_pkg::RegImageWidth, w);
    cfg_idx_i   <= sedt_pkg::RegImageHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    sb.write_reg(sedt_pkg::RegImageHeight, h);
    cfg_idx_i   <= sedt_pkg::RegSeamDirection;
    cfg_wdata_i <= sedt_pkg::CfgDataW'(d);
    @(posedge clk_i);
    sb.write_reg(sedt_pkg::RegSeamDirection, sedt_pkg::CfgDataW'(d));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [sedt_pkg::EnergyW-1:0] pick_energy(input int unsigned top_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < top_pct) return '1;
    if (r < top_pct + 10) return '0;
    return sedt_pkg::EnergyW'($urandom_range(255));
  endfunction

  task automatic run_phase(input logic [sedt_pkg::CfgDataW-1:0] w,
                           input logic [sedt_pkg::CfgDataW-1:0] h,
                           input logic d, input int unsigned top_pct,
                           input int unsigned frames);
    int unsigned len, cnt, n;
    configure(w, h, d);
    len = sb.line_length();
    cnt = sb.line_total();
    // now and then cut a frame short and restart it with a register write
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, len*cnt)) send_pixel(pick_energy(top_pct));
      drain();
      configure(w, h, d);
    end
    repeat (frames) begin
      for (int i = 0; i < len*cnt; i++) begin
        if ($urandom_range(99) < 3) send_trace();
        send_pixel(pick_energy(top_pct));
      end
      n = (2*cnt + 1 > MaxTraces) ? MaxTraces : 2*cnt + 1;
      repeat (n) begin
        if ($urandom_range(99) < 3) send_pixel(pick_energy(top_pct));
        send_trace();
      end
    end
    drain();
  endtask

  initial begin
    logic [sedt_pkg::EnergyW-1:0] grid3 [9];
    grid3 = '{8'd255, 8'd0, 8'd255,
              8'd0,   8'd0, 8'd0,
              8'd10, 8'd255, 8'd10};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // trace right after reset, no frame yet
    send_trace();
    drain();
    configure(10'd3, 10'd3, 1'b0);
    // 3x3 frame with ties, clamped edges and a trace in the middle of it
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_trace();
      send_pixel(grid3[i]);
    end
    repeat (4) send_trace();
    // pixels after a complete frame begin a new one
    send_pixel(8'd7);
    send_pixel(8'd128);
    drain();
    // horizontal seam, zero height acts as a one pixel line
    configure(10'd2, 10'd0, 1'b1);
    send_pixel(8'd200);
    send_pixel(8'd55);
    send_trace();
    send_trace();
    drain();

    for (int k = 0; words_in < RandomWords || k <= 12; k++) begin
      steady = (k == 4);
      if (k == 4) begin
        run_phase(10'd20, 10'd10, 1'b0, 10, 1);
      end else if (k == 6) begin
        // longest line, sink held off while words keep coming
        hold_sink = 1'b1;
        run_phase(10'd0, 10'h3FF, 1'b1, 10, 1);
      end else if (k == 12) begin
        // most lines, energies mostly at the top for the largest sums
        run_phase(10'd1, 10'd700, 1'b0, 90, 1);
      end else begin
        run_phase(sedt_pkg::CfgDataW'($urandom_range(8)),
                  sedt_pkg::CfgDataW'($urandom_range(8)),
                  1'($urandom_range(1)), 10, $urandom_range(1, 2));
      end
    end

    $display("covered %0d words over %0d size and direction settings, %0d results",
             words_in, settings, sb.checked);
    $display("seam steps read %0d, traces refused before frame end %0d",
             sb.seams_read, sb.early_traces);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sedt_pkg.sv
rtl/sedt_ctrl.sv
rtl/sedt_dpath.sv
rtl/seam_energy_dp_and_trace_core.sv
test/tb_top.sv
